// File: rtl/xbr_pkg.sv
`default_nettype none

package xbr_pkg;

	// Default block size and reset value of the NAK timeout register.
	localparam int PAYLOAD_BYTES_DEF = 128;
	localparam logic [23:0] NAK_TIMEOUT_RESET = 24'd300000;

	// Depth of the queue between the classifying front and the output back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Protocol control bytes.
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] NAK_BYTE = 8'h15;

	// Input operation codes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_BYTE  = 2'd2;

	// Kind of a result item.
	typedef enum logic [1:0] {
		KIND_STORE = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_NAK   = 2'd2
	} kind_t;

	// Receiver phase.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_START   = 2'd1,
		PH_BLOCK   = 2'd2,
		PH_BETWEEN = 2'd3
	} phase_t;

	// One queued action: a first result, optionally followed by an ACK.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [15:0] block;
		logic [7:0]  pos;
		logic        done;
		logic        ack_after;
	} entry_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// File: rtl/xbr_front.sv
`default_nettype none

module xbr_front #(
	parameter int PAYLOAD_BYTES = xbr_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,
	input  wire logic [1:0]      s_tuser,
	input  wire logic            cfg_we,
	input  wire logic [23:0]     cfg_data,
	input  wire xbr_pkg::qstat_t qstat,
	output logic                 push,
	output xbr_pkg::entry_t      entry
);
	import xbr_pkg::*;

	localparam int POS_W = $clog2(PAYLOAD_BYTES + 3);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES + 2);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [23:0]      idle_q, idle_d, idle_inc;
	logic [15:0]      blk_q, blk_d;
	logic [23:0]      timeout_q;
	logic             accept;

	// An item is taken whenever the queue has room for its action.
	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= NAK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			idle_q  <= '0;
			blk_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			idle_q  <= idle_d;
			blk_q   <= blk_d;
		end
	end

	// Classify the item, update the state and build the queued action.
	always_comb begin
		phase_d         = phase_q;
		pos_d           = pos_q;
		idle_d          = idle_q;
		blk_d           = blk_q;
		push            = 1'b0;
		idle_inc        = idle_q + 24'd1;
		entry.kind      = KIND_NAK;
		entry.value     = NAK_BYTE;
		entry.block     = blk_q;
		entry.pos       = '0;
		entry.done      = 1'b0;
		entry.ack_after = 1'b0;
		if (accept) begin
			case (s_tuser)
				OP_START: begin
					phase_d     = PH_START;
					pos_d       = '0;
					idle_d      = '0;
					blk_d       = '0;
					entry.block = '0;
					push        = 1'b1;
				end
				OP_TICK: begin
					if (phase_q == PH_START) begin
						idle_d = idle_inc;
						if (idle_inc >= timeout_q) begin
							idle_d = '0;
							push   = 1'b1;
						end
					end
				end
				OP_BYTE: begin
					case (phase_q)
						PH_START, PH_BETWEEN: begin
							if (s_tdata == EOT_BYTE) begin
								entry.kind  = KIND_ACK;
								entry.value = ACK_BYTE;
								entry.done  = 1'b1;
								push        = 1'b1;
								phase_d     = PH_IDLE;
								pos_d       = '0;
								idle_d      = '0;
							end else begin
								if (phase_q == PH_BETWEEN) begin
									blk_d = blk_q + 16'd1;
								end
								phase_d = PH_BLOCK;
								pos_d   = '0;
							end
						end
						PH_BLOCK: begin
							entry.kind  = KIND_STORE;
							entry.value = s_tdata;
							entry.pos   = 8'(pos_q);
							push        = 1'b1;
							if (pos_q >= POS_LAST) begin
								entry.ack_after = 1'b1;
								phase_d         = PH_BETWEEN;
								pos_d           = '0;
							end else begin
								pos_d = pos_q + POS_W'(1);
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/xbr_queue.sv
`default_nettype none

module xbr_queue #(
	parameter int DEPTH = xbr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire xbr_pkg::entry_t wr_entry,
	input  wire logic            pop,
	output xbr_pkg::entry_t      head,
	output xbr_pkg::qstat_t      qstat
);
	import xbr_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

// File: rtl/xbr_back.sv
`default_nettype none

module xbr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire xbr_pkg::qstat_t qstat,
	input  wire xbr_pkg::entry_t head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata,
	output logic [2:0]           m_tuser,
	output logic                 m_tlast
);
	import xbr_pkg::*;

	logic        valid_q;
	logic        second_q;
	logic [15:0] second_block_q;
	kind_t       kind_q;
	logic [7:0]  value_q;
	logic [15:0] block_q;
	logic [7:0]  pos_q;
	logic        done_q;
	logic        last_q;
	logic        load;

	// The output register may be refilled when empty or being taken.
	assign load = !valid_q || m_tready;
	assign pop  = load && !second_q && !qstat.empty;

	// Control part of the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else if (!qstat.empty) begin
				valid_q  <= 1'b1;
				second_q <= head.ack_after;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload of the output stage: the queued result, then its trailing ACK.
	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				kind_q  <= KIND_ACK;
				value_q <= ACK_BYTE;
				block_q <= second_block_q;
				pos_q   <= '0;
				done_q  <= 1'b0;
				last_q  <= 1'b1;
			end else if (!qstat.empty) begin
				kind_q         <= head.kind;
				value_q        <= head.value;
				block_q        <= head.block;
				pos_q          <= head.pos;
				done_q         <= head.done;
				last_q         <= !head.ack_after;
				second_block_q <= head.block;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {pos_q, block_q, value_q};
	assign m_tuser  = {done_q, kind_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// File: rtl/xmodem_block_receiver_unit.sv
`default_nettype none
// The first result of an item is written into the queue when the item is accepted, then moves
// on into the output stage register, where it is held until it is taken.
// Items are taken at one item per cycle while the queue is not full; the checksum byte yields
// two results, the stored byte followed by its ACK, the rest of the rate set by the queue.
// Reset (arst_n low, asynchronous): idle phase, counters and block number zero,
// queue and output stage empty, NAK timeout register back to 300000 ticks.

module xmodem_block_receiver_unit #(
	parameter int PAYLOAD_BYTES = xbr_pkg::PAYLOAD_BYTES_DEF,
	parameter int QUEUE_DEPTH   = xbr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_data,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [7:0] byte_value, [23:8] block_number,
	                                   // [31:24] byte_position
	output logic [2:0]       m_tuser,  // [1:0] result_kind, [2] transfer_done
	output logic             m_tlast   // last_of_run
);
	import xbr_pkg::*;

	qstat_t qstat;
	entry_t wr_entry;
	entry_t head;
	logic   push;
	logic   pop;

	// Front: takes items, tracks the transfer and queues actions.
	xbr_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.qstat   (qstat),
		.push    (push),
		.entry   (wr_entry)
	);

	// Queue between front and back.
	xbr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	// Back: expands actions into result items.
	xbr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

// File: rtl/xbr_checker.sv
`default_nettype none

module xbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);
	import xbr_pkg::*;

	// A stalled result item holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result item changed");

	// A result that is not the last of its run is followed at once by the ACK.
	a_ack_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast
			&& (m_tuser[1:0] == KIND_ACK) && (m_tdata[7:0] == ACK_BYTE))
		else $error("checksum store not followed by ACK");

	// The end of a transfer is flagged only on a lone ACK.
	a_done_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == KIND_ACK) && m_tlast
			&& (m_tdata[7:0] == ACK_BYTE) && (m_tdata[31:24] == 8'd0))
		else $error("transfer done on a result that is not a final ACK");

	// A NAK carries the NAK byte, position zero and closes its run.
	a_nak_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_NAK) |-> m_tlast && !m_tuser[2]
			&& (m_tdata[7:0] == NAK_BYTE) && (m_tdata[31:24] == 8'd0))
		else $error("malformed NAK result");

endmodule

bind xmodem_block_receiver_unit xbr_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire

// File: bench/xmodem_block_receiver_unit_tb.sv
`timescale 1ns / 1ps

import xbr_pkg::*;

// One result item as the receiver is expected to deliver it.
typedef struct packed {
	kind_t       kind;
	logic [7:0]  value;
	logic [15:0] block;
	logic [7:0]  pos;
	logic        done;
	logic        last;
} rx_result_t;

// Tracks the receiver's protocol state and holds the results still owed by the block.
class transfer_tracker;
	localparam int BLOCK_BYTES = PAYLOAD_BYTES_DEF;

	rx_result_t  awaited_results[$];
	phase_t      phase;
	logic [7:0]  pos_count;
	logic [23:0] idle_ticks;
	logic [15:0] block_idx;
	logic [23:0] timeout;
	int          errors;

	function new();
		phase      = PH_IDLE;
		pos_count  = '0;
		idle_ticks = '0;
		block_idx  = '0;
		timeout    = NAK_TIMEOUT_RESET;
		errors     = 0;
	endfunction

	function void set_timeout(logic [23:0] value);
		timeout = value;
	endfunction

	function int pending();
		return awaited_results.size();
	endfunction

	function void owe(kind_t kind, logic [7:0] value, logic [7:0] pos, logic done);
		rx_result_t r;
		r.kind  = kind;
		r.value = value;
		r.block = block_idx;
		r.pos   = pos;
		r.done  = done;
		r.last  = 1'b0;
		awaited_results.push_back(r);
	endfunction

	// Works out the results caused by one accepted input item.
	function void take_item(logic [1:0] op, logic [7:0] rx_byte);
		int first;
		first = awaited_results.size();
		case (op)
			OP_START: begin
				phase      = PH_START;
				pos_count  = '0;
				idle_ticks = '0;
				block_idx  = '0;
				owe(KIND_NAK, NAK_BYTE, 8'd0, 1'b0);
			end
			OP_TICK: begin
				// Ticks only matter while waiting for the first header.
				if (phase == PH_START) begin
					idle_ticks = idle_ticks + 24'd1;
					if (idle_ticks >= timeout) begin
						idle_ticks = '0;
						owe(KIND_NAK, NAK_BYTE, 8'd0, 1'b0);
					end
				end
			end
			OP_BYTE: begin
				if (phase == PH_START || phase == PH_BETWEEN) begin
					// A header byte: end of transmission, or the start of a block.
					if (rx_byte == EOT_BYTE) begin
						owe(KIND_ACK, ACK_BYTE, 8'd0, 1'b1);
						phase      = PH_IDLE;
						pos_count  = '0;
						idle_ticks = '0;
					end else begin
						if (phase == PH_BETWEEN)
							block_idx = block_idx + 16'd1;
						phase     = PH_BLOCK;
						pos_count = '0;
					end
				end else if (phase == PH_BLOCK) begin
					owe(KIND_STORE, rx_byte, pos_count, 1'b0);
					if (pos_count >= BLOCK_BYTES + 2) begin
						owe(KIND_ACK, ACK_BYTE, 8'd0, 1'b0);
						phase     = PH_BETWEEN;
						pos_count = '0;
					end else begin
						pos_count = pos_count + 8'd1;
					end
				end
			end
			default: ;
		endcase
		if (awaited_results.size() > first)
			awaited_results[awaited_results.size() - 1].last = 1'b1;
	endfunction

	function void field_check(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compares one delivered result item with the oldest one owed.
	function void match_result(logic [31:0] data, logic [2:0] user, logic last);
		rx_result_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t ns: unexpected result, expected none, actual data %h user %h last %b",
				$time, data, user, last);
			errors++;
			return;
		end
		want = awaited_results.pop_front();
		field_check("result_kind", want.kind, user[1:0]);
		field_check("transfer_done", want.done, user[2]);
		field_check("byte_value", want.value, data[7:0]);
		field_check("block_number", want.block, data[23:8]);
		field_check("byte_position", want.pos, data[31:24]);
		field_check("last_of_run", want.last, last);
	endfunction
endclass

module xmodem_block_receiver_unit_tb;

	localparam int BLOCK_BYTES    = PAYLOAD_BYTES_DEF;
	localparam int ITEM_TARGET    = 1850;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	// Operation code that the block has to ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_data = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	transfer_tracker tracker;
	bit steady_flow = 1'b0;
	int items_sent = 0;
	int sink_hold = 0;
	int quiet_cycles = 0;

	xmodem_block_receiver_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long; none at all in steady stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Result side: check each accepted item, then decide on stalling.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			tracker.match_result(m_tdata, m_tuser, m_tlast);
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_tready <= 1'b1;
			sink_hold = pick_gap();
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one input item after a random gap and waits for it to be taken.
	task automatic send_item(input logic [1:0] op, input logic [7:0] rx_byte);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= rx_byte;
		do @(posedge clk); while (!s_tready);
		tracker.take_item(op, rx_byte);
		items_sent++;
	endtask

	// Holds the sender off until every owed result has arrived and the block is quiet.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [23:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_timeout(value);
	endtask

	// One transfer: start, a few ticks, some blocks and the closing EOT; sometimes cut short.
	task automatic run_transfer();
		int blocks;
		int cut_blk;
		int cut_pos;
		logic [7:0] hdr;
		blocks  = $urandom_range(1, 3);
		cut_blk = -1;
		cut_pos = 0;
		if ($urandom_range(0, 5) == 0) begin
			cut_blk = $urandom_range(0, blocks - 1);
			cut_pos = $urandom_range(0, BLOCK_BYTES + 2);
		end
		send_item(OP_START, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 6)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0)
			send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
		for (int blk = 0; blk < blocks; blk++) begin
			do hdr = 8'($urandom_range(0, 255)); while (hdr == EOT_BYTE);
			send_item(OP_BYTE, hdr);
			for (int p = 0; p <= BLOCK_BYTES + 2; p++) begin
				if (blk == cut_blk && p == cut_pos)
					return;
				if ($urandom_range(0, 49) == 0)
					send_item($urandom_range(0, 1) ? OP_TICK : OP_UNUSED,
						8'($urandom_range(0, 255)));
				if (blk == 0 && p == 60 && $urandom_range(0, 2) == 0)
					drain_results();
				send_item(OP_BYTE, 8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 3) == 0)
				send_item(OP_TICK, 8'($urandom_range(0, 255)));
		end
		send_item(OP_BYTE, EOT_BYTE);
		// Traffic after the transfer has ended is ignored.
		if ($urandom_range(0, 3) == 0) begin
			send_item(OP_TICK, 8'($urandom_range(0, 255)));
			send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		end
	endtask

	// Stimulus sequence.
	initial begin
		logic [23:0] next_timeout;
		int round;
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: ignored items, repeated NAK, EOT as the first header, restarts.
		write_timeout(24'd2);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_TICK, 8'h00);
		send_item(OP_UNUSED, 8'hAA);
		send_item(OP_START, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_BYTE, EOT_BYTE);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_START, 8'hFF);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h01);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h01);
		send_item(OP_BYTE, 8'hFE);
		send_item(OP_BYTE, EOT_BYTE);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_START, 8'h55);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h00);

		// Random transfers under changing timeout settings.
		round = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			case (round % 5)
				0: next_timeout = 24'd1;
				1: next_timeout = 24'd0;
				2: next_timeout = 24'hFFFFFF;
				3: next_timeout = 24'($urandom_range(2, 12));
				default: next_timeout = NAK_TIMEOUT_RESET;
			endcase
			write_timeout(next_timeout);
			steady_flow = ($urandom_range(0, 3) == 0);
			run_transfer();
			round++;
		end

		// Let the block finish and check that nothing more comes out.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
